@@ hdl/cma_pkg.sv @@
// Shared constants, types and codes for the centred moving average block.
package cma_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int CHANNELS_MAX = 16;

    localparam int DATA_W    = 32;
    localparam int CH_W      = $clog2(CHANNELS_MAX);
    localparam int SLOT_W    = $clog2(WINDOW_MAX);
    localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
    localparam int CCNT_W    = $clog2(CHANNELS_MAX + 1);
    localparam int SUM_W     = DATA_W + SLOT_W;
    localparam int CELL_W    = SLOT_W + CH_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam int WS_W  = 7;
    localparam int CC_W  = 5;
    localparam int CFG_W = 7;

    localparam int WS_RESET = 8;
    localparam int CC_RESET = 1;

    typedef enum logic [0:0] {
        REG_WINDOW_SIZE   = 1'b0,
        REG_CHANNEL_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hdl/cma_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cma_div.sv @@
// Bit-serial restoring divider: signed sum by small unsigned count, truncating.
module cma_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [cma_pkg::SUM_W-1:0]  i_dividend,
    input  logic [cma_pkg::CNT_W-1:0]         i_divisor,
    output cma_pkg::t_div_stat                o_stat,
    output logic signed [cma_pkg::DATA_W-1:0] o_quotient
);
    import cma_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_dvs;
    logic [CNT_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_quo;

    logic [CNT_W:0]       trial;
    logic                 fits;
    logic [CNT_W-1:0]     n_rem;
    logic [SUM_W-1:0]     mag;
    logic [DATA_W-1:0]    low;

    // one quotient bit per cycle: shift the next dividend bit into the remainder
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        n_rem = fits ? CNT_W'(trial - {1'b0, r_dvs}) : trial[CNT_W-1:0];
        mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= mag;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign low           = r_quo[DATA_W-1:0];
    assign o_quotient    = r_neg ? -low : low;
    assign o_stat.busy   = r_busy;
    assign o_stat.done   = r_done;

endmodule

@@ hdl/centered_moving_average_multichannel.sv @@
// Top level: per-channel centred boxcar average with a bit-serial divider.
// An accepted transaction passes one RAM read, one divider load, 38 divider steps, one
// completion and one output load, which waits while the output is stalled.
// Input stalls until the block is idle, so a new item waits until the last is through;
// ramp-in items end after the memory update, and out-of-range channels cause no stall.
// Reset (synchronous, active low) clears control, channel sums and the registers to
// window 8, one channel; the delay memories are not cleared.
module centered_moving_average_multichannel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  cma_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [cma_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cma_pkg::DATA_W-1:0]        i_time_stamp,
    input  logic [cma_pkg::CH_W-1:0]          i_channel,
    input  logic signed [cma_pkg::DATA_W-1:0] i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cma_pkg::DATA_W-1:0]        o_center_time,
    output logic [cma_pkg::CH_W-1:0]          o_out_channel,
    output logic signed [cma_pkg::DATA_W-1:0] o_average
);
    import cma_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [WS_W-1:0]   r_ws;
    logic [CC_W-1:0]   r_cc;
    logic [CNT_W-1:0]  r_step;
    logic [SLOT_W-1:0] r_wslot;
    logic signed [SUM_W-1:0] r_sums [CHANNELS_MAX];

    logic [DATA_W-1:0]        r_ts;
    logic [CH_W-1:0]          r_ch;
    logic signed [DATA_W-1:0] r_smp;
    logic                     r_full;
    logic                     r_emit;
    logic                     r_last;
    logic [CNT_W-1:0]         r_dvs;
    logic [DATA_W-1:0]        r_ctime;

    logic                     r_o_valid;
    logic [DATA_W-1:0]        r_o_time;
    logic [CH_W-1:0]          r_o_ch;
    logic signed [DATA_W-1:0] r_o_avg;

    logic [CNT_W-1:0]  w_eff;
    logic [CCNT_W-1:0] c_eff;
    logic [CNT_W-1:0]  half;
    logic [CNT_W:0]    tsum;
    logic [SLOT_W-1:0] tslot;
    logic              in_acc;
    logic              ch_ok;
    logic              take;
    logic              out_free;

    logic              stall_c;
    logic              upd_we;
    logic              div_start;
    logic              load_out;

    logic [DATA_W-1:0] smp_rdata;
    logic [DATA_W-1:0] time_rdata;
    logic [DATA_W-1:0] old_smp;
    logic signed [SUM_W-1:0] n_sum;

    t_div_stat                div_stat;
    logic signed [DATA_W-1:0] div_q;

    // effective register values after clamping
    always_comb begin
        if (r_ws < WS_W'(2)) begin
            w_eff = CNT_W'(2);
        end else if (CNT_W'(r_ws) > CNT_W'(WINDOW_MAX)) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(r_ws);
        end
        if (r_cc == '0) begin
            c_eff = CCNT_W'(1);
        end else if (CCNT_W'(r_cc) > CCNT_W'(CHANNELS_MAX)) begin
            c_eff = CCNT_W'(CHANNELS_MAX);
        end else begin
            c_eff = CCNT_W'(r_cc);
        end
        half  = w_eff >> 1;
        // centre slot lies h steps back in the ring
        tsum  = {1'b0, CNT_W'(r_wslot)} + {1'b0, CNT_W'(w_eff - half)};
        tslot = (tsum >= {1'b0, w_eff}) ? SLOT_W'(tsum - {1'b0, w_eff}) : SLOT_W'(tsum);
    end

    assign in_acc   = i_valid && !o_stall;
    assign ch_ok    = CCNT_W'(i_channel) < c_eff;
    assign take     = in_acc && ch_ok;
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (take) n_state = S_READ;
            S_READ:  n_state = r_emit ? S_START : S_IDLE;
            S_START: n_state = S_DIV;
            S_DIV:   if (div_stat.done) n_state = S_LOAD;
            S_LOAD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        stall_c   = 1'b1;
        upd_we    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE:  stall_c   = 1'b0;
            S_READ:  upd_we    = 1'b1;
            S_START: div_start = 1'b1;
            S_DIV:   stall_c   = 1'b1;
            S_LOAD:  load_out  = out_free;
            default: stall_c   = 1'b1;
        endcase
    end

    assign o_stall = stall_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration; any write restarts the stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_W'(WS_RESET);
            r_cc <= CC_W'(CC_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_SIZE:   r_ws <= i_cfg_data[WS_W-1:0];
                REG_CHANNEL_COUNT: r_cc <= i_cfg_data[CC_W-1:0];
                default:           r_ws <= r_ws;
            endcase
        end
    end

    assign old_smp = r_full ? smp_rdata : '0;
    assign n_sum   = r_sums[r_ch]
                   + {{(SUM_W-DATA_W){r_smp[DATA_W-1]}}, r_smp}
                   - {{(SUM_W-DATA_W){old_smp[DATA_W-1]}}, old_smp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_step  <= '0;
            r_wslot <= '0;
            for (int i = 0; i < CHANNELS_MAX; i++) begin
                r_sums[i] <= '0;
            end
        end else if (upd_we) begin
            r_sums[r_ch] <= n_sum;
            if (r_last) begin
                r_wslot <= (CNT_W'(r_wslot) + 1'b1 >= w_eff) ? '0 : r_wslot + 1'b1;
                if (r_step < w_eff) begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // hold the transaction while it is worked on
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ts   <= i_time_stamp;
            r_ch   <= i_channel;
            r_smp  <= i_sample;
            r_full <= r_step >= w_eff;
            r_emit <= r_step >= half;
            r_last <= CCNT_W'(i_channel) == c_eff - 1'b1;
            r_dvs  <= (r_step >= w_eff) ? w_eff : r_step + 1'b1;
        end
        if (upd_we) begin
            r_ctime <= time_rdata;
        end
    end

    cma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX * CHANNELS_MAX)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr ({r_wslot, r_ch}),
        .i_wdata (r_smp),
        .i_raddr (CELL_W'({r_wslot, i_channel})),
        .o_rdata (smp_rdata)
    );

    cma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr (r_wslot),
        .i_wdata (r_ts),
        .i_raddr (tslot),
        .o_rdata (time_rdata)
    );

    cma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sums[r_ch]),
        .i_divisor  (r_dvs),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_time <= r_ctime;
            r_o_ch   <= r_ch;
            r_o_avg  <= div_q;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_center_time = r_o_time;
    assign o_out_channel = r_o_ch;
    assign o_average     = r_o_avg;

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> r_state == S_DIV)
        else $error("divider busy outside the divide state");

    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_wslot) < w_eff)
        else $error("write slot beyond the window");

    a_step_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= w_eff)
        else $error("step count beyond the window");

    a_read_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> $past(take))
        else $error("memory read stage entered without an accepted transaction");

endmodule

@@ bench/centered_moving_average_multichannel_tb.sv @@
// Self-checking bench for the multichannel centred moving average: directed and random streams.
module centered_moving_average_multichannel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cma_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 50;
    localparam int IDLE_PERCENT  = 32;

    typedef struct packed {
        logic [DATA_W-1:0]        center_time;
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] average;
    } t_mean;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    t_cfg_reg                 i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [DATA_W-1:0]        i_time_stamp;
    logic [CH_W-1:0]          i_channel;
    logic signed [DATA_W-1:0] i_sample;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [DATA_W-1:0]        o_center_time;
    logic [CH_W-1:0]          o_out_channel;
    logic signed [DATA_W-1:0] o_average;

    // predictor state
    logic signed [DATA_W-1:0] sample_ring [WINDOW_MAX*CHANNELS_MAX];
    logic [DATA_W-1:0]        stamp_ring [WINDOW_MAX];
    logic signed [SUM_W-1:0]  chan_sum [CHANNELS_MAX];
    logic [CNT_W-1:0]         steps_seen;
    logic [SLOT_W-1:0]        ring_slot;
    logic [WS_W-1:0]          window_reg;
    logic [CC_W-1:0]          channels_reg;

    t_mean       pending_means [$];
    t_mean       oldest_mean;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          steady_flow = 1'b0;
    int unsigned holdoff_len = 0;
    int unsigned holdoff_req = 0;
    int unsigned holdoff_left = 0;
    int unsigned holdoff_seen = 0;
    logic [DATA_W-1:0] stamp_now = '0;

    centered_moving_average_multichannel u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_time_stamp (i_time_stamp),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_center_time(o_center_time),
        .o_out_channel(o_out_channel),
        .o_average    (o_average)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("centered_moving_average_multichannel regression: fail");
            $finish;
        end
    end

    // Fold one accepted sample into the running sums and queue the average it yields.
    function automatic void average_step(input logic [DATA_W-1:0] ts,
                                         input logic [CH_W-1:0] ch,
                                         input logic signed [DATA_W-1:0] smp);
        int unsigned w;
        int unsigned c;
        int unsigned h;
        int unsigned ring_idx;
        int unsigned tslot;
        longint      divisor;
        longint      quotient;
        bit          full;
        t_mean       entry;
        w = window_reg;
        if (w < 2) w = 2;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        c = channels_reg;
        if (c < 1) c = 1;
        if (c > CHANNELS_MAX) c = CHANNELS_MAX;
        h = w / 2;
        if (ch >= c) return;
        if (ring_slot >= w) ring_slot = '0;
        ring_idx = ring_slot * CHANNELS_MAX + ch;
        full = (steps_seen >= w);
        stamp_ring[ring_slot] = ts;
        chan_sum[ch] = chan_sum[ch] + smp;
        if (full) chan_sum[ch] = chan_sum[ch] - sample_ring[ring_idx];
        sample_ring[ring_idx] = smp;
        if (steps_seen >= h) begin
            tslot = (ring_slot + w - h) % w;
            divisor = full ? longint'(w) : longint'(steps_seen) + 1;
            quotient = longint'(chan_sum[ch]) / divisor;
            entry.center_time = stamp_ring[tslot];
            entry.channel = ch;
            entry.average = quotient[DATA_W-1:0];
            pending_means.push_back(entry);
        end
        // the last channel closes the time step
        if (ch == c - 1) begin
            ring_slot = (ring_slot + 1 >= w) ? '0 : ring_slot + 1'b1;
            if (steps_seen < w) steps_seen = steps_seen + 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_means.size() == 0) begin
                report_mismatch("transaction with nothing pending", o_average, '0);
            end else begin
                oldest_mean = pending_means.pop_front();
                if (o_center_time !== oldest_mean.center_time)
                    report_mismatch("center_time", o_center_time, oldest_mean.center_time);
                if (o_out_channel !== oldest_mean.channel)
                    report_mismatch("out_channel", 32'(o_out_channel), 32'(oldest_mean.channel));
                if (o_average !== oldest_mean.average)
                    report_mismatch("average", o_average, oldest_mean.average);
            end
        end
    end

    // Output side: random back-pressure, plus a long hold when one is requested.
    always @(posedge i_clk) begin : receiver
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            holdoff_left = holdoff_len;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(65535);
            3: return -$urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_sample(input logic [DATA_W-1:0] ts, input logic [CH_W-1:0] ch,
                               input logic [DATA_W-1:0] smp);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_time_stamp <= ts;
        i_channel    <= ch;
        i_sample     <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        average_step(ts, ch, smp);
    endtask

    // Drop valid, wait for every pending average, then let the block settle.
    task automatic wait_until_idle();
        i_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] value);
        wait_until_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW_SIZE) window_reg = value[WS_W-1:0];
        else channels_reg = value[CC_W-1:0];
        // a register write restarts the stream; the delay lines keep their contents
        foreach (chan_sum[k]) chan_sum[k] = '0;
        steps_seen = '0;
        ring_slot  = '0;
    endtask

    // One full time step: every channel once, the last one closing it,
    // sometimes shuffled, repeated or salted with ignored channels.
    task automatic send_step(input int unsigned chans, input logic [DATA_W-1:0] ts);
        logic [CH_W-1:0] order [$];
        logic [CH_W-1:0] tmp;
        int unsigned     pick;
        for (int k = 0; k + 1 < chans; k++) order.push_back(k[CH_W-1:0]);
        if (chans > 2 && $urandom_range(99) < 15) begin
            for (int k = order.size() - 1; k > 0; k--) begin
                pick = $urandom_range(k);
                tmp = order[k];
                order[k] = order[pick];
                order[pick] = tmp;
            end
        end
        if (chans > 1 && $urandom_range(99) < 8)
            order.insert($urandom_range(order.size()), order[$urandom_range(order.size() - 1)]);
        if (chans < CHANNELS_MAX && $urandom_range(99) < 10)
            order.insert($urandom_range(order.size()),
                         CH_W'($urandom_range(chans, CHANNELS_MAX - 1)));
        order.push_back(CH_W'(chans - 1));
        for (int k = 0; k < order.size(); k++) send_sample(ts, order[k], random_sample());
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] win_code, input logic [CFG_W-1:0] chan_code,
                             input int unsigned n_steps, input int pause_at,
                             input int unsigned hold_cycles);
        int unsigned chans;
        chans = chan_code[CC_W-1:0];
        if (chans < 1) chans = 1;
        if (chans > CHANNELS_MAX) chans = CHANNELS_MAX;
        write_reg(REG_WINDOW_SIZE, win_code);
        write_reg(REG_CHANNEL_COUNT, chan_code);
        if (hold_cycles > 0) begin
            holdoff_len = hold_cycles;
            holdoff_req++;
        end
        for (int s = 0; s < n_steps; s++) begin
            if (s == pause_at) wait_until_idle();
            if ($urandom_range(9) == 0) stamp_now = $urandom;
            else stamp_now = stamp_now + $urandom_range(1, 32'h0002_0000);
            send_step(chans, stamp_now);
        end
    endtask

    // Reset values: window 8, one channel; extreme samples and stamps, one ignored channel.
    task automatic test_reset_defaults();
        logic [DATA_W-1:0] samples [10] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                            32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                            32'h0000_0001};
        for (int i = 0; i < 10; i++) begin
            send_sample((i == 2) ? 32'hFFFF_FFFF : 32'(i) << 16, '0, samples[i]);
            if (i == 5) send_sample(32'h0005_0000, 4'hF, 32'h1234_5678);
        end
    endtask

    // Zero in both registers: smallest window, one channel; odd negative sums truncate toward zero.
    task automatic test_low_clamps();
        write_reg(REG_WINDOW_SIZE, 7'd0);
        write_reg(REG_CHANNEL_COUNT, 7'd0);
        send_sample(32'h0000_0000, '0, 32'sd1);
        send_sample(32'h0001_0000, '0, -32'sd4);
        send_sample(32'h0002_0000, '0, 32'sd6);
        send_sample(32'h0003_0000, '0, -32'sd9);
    endtask

    // Window one acts as two; three channels with swapped, ignored and repeated channels.
    task automatic test_channel_order();
        write_reg(REG_WINDOW_SIZE, 7'd1);
        write_reg(REG_CHANNEL_COUNT, 7'd3);
        send_sample(32'h0010_0000, 4'd1, random_sample());
        send_sample(32'h0010_0000, 4'd0, random_sample());
        send_sample(32'h0010_0000, 4'd2, random_sample());
        send_sample(32'h0011_0000, 4'd0, random_sample());
        send_sample(32'h0011_0000, 4'd1, random_sample());
        send_sample(32'h0011_0000, 4'd3, random_sample());
        send_sample(32'h0011_0000, 4'd2, random_sample());
        send_sample(32'h0012_0000, 4'd0, random_sample());
        send_sample(32'h0012_0000, 4'd0, random_sample());
        send_sample(32'h0012_0000, 4'd1, random_sample());
        send_sample(32'h0012_0000, 4'd15, random_sample());
        send_sample(32'h0012_0000, 4'd2, random_sample());
        send_sample(32'h0013_0000, 4'd0, random_sample());
        send_sample(32'h0013_0000, 4'd1, random_sample());
        send_sample(32'h0013_0000, 4'd2, random_sample());
    endtask

    // Widest window (all-ones write), with a full drain partway through.
    task automatic test_widest_window();
        run_phase(7'h7F, 7'd1, 72, 40, 0);
    endtask

    // Channel count above the maximum, streamed with no idling on either side.
    task automatic test_all_channels();
        steady_flow = 1'b1;
        run_phase(7'd2, 7'd31, 6, -1, 0);
        steady_flow = 1'b0;
    endtask

    // Hold the output off long enough for the block to stall its input.
    task automatic test_output_holdoff();
        run_phase(7'd5, 7'd3, 20, -1, 400);
    endtask

    task automatic test_random_settings();
        int unsigned w;
        int unsigned c;
        int unsigned n;
        repeat (3) begin
            w = $urandom_range(2, 20);
            c = $urandom_range(0, 8);
            n = w + 4;
            if (n * ((c == 0) ? 1 : c) < 70) n = 70 / ((c == 0) ? 1 : c);
            run_phase(w[CFG_W-1:0], c[CFG_W-1:0], n, -1, 0);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= REG_WINDOW_SIZE;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_time_stamp <= '0;
        i_channel    <= '0;
        i_sample     <= '0;
        foreach (sample_ring[k]) sample_ring[k] = '0;
        foreach (stamp_ring[k]) stamp_ring[k] = '0;
        foreach (chan_sum[k]) chan_sum[k] = '0;
        steps_seen   = '0;
        ring_slot    = '0;
        window_reg   = WS_W'(WS_RESET);
        channels_reg = CC_W'(CC_RESET);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_low_clamps();
        test_channel_order();
        test_widest_window();
        test_all_channels();
        test_output_holdoff();
        test_random_settings();

        wait_until_idle();
        if (error_count == 0) begin
            $display("centered_moving_average_multichannel regression: pass");
        end else begin
            $display("centered_moving_average_multichannel regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/cma_pkg.sv
hdl/cma_ram.sv
hdl/cma_div.sv
hdl/centered_moving_average_multichannel.sv
bench/centered_moving_average_multichannel_tb.sv
